/* hdl/sfir_pkg.sv */
// sfir_pkg: shared constants, command codes and control struct for the stereo fir filter
// depends on nothing; imported by the interfaces and every module of the block but sfir_ram
package sfir_pkg;

  // default configuration
  localparam int TAPS_DEF        = 40;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int WEIGHT_BITS_DEF = 18;

  // fixed field width of the coefficient position
  localparam int INDEX_BITS = 6;

  // the accumulator never grows past this width; sums wrap modulo 2^64 beyond it
  localparam int ACC_LIMIT = 64;

  // command codes of an input item
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // per-tap control from the sequencer to the multiply-accumulate lanes
  typedef struct packed {
    logic clear;     // zero the accumulator at the start of a sample
    logic mul_en;    // memory read data valid, capture a product
    logic mul_zero;  // tap not yet written or history older than the stream
    logic acc_en;    // add the captured product
  } mac_ctrl_t;

endpackage

/* hdl/sfir_in_if.sv */
// sfir_in_if: input channel of the stereo fir filter, valid/ready with item payload
// depends on sfir_pkg
interface sfir_in_if import sfir_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic        [INDEX_BITS-1:0]  tap_index;
  logic signed [WEIGHT_BITS-1:0] tap_weight;

  modport source (
    output valid, command, left_sample, right_sample, tap_index, tap_weight,
    input  ready
  );
  modport sink (
    input  valid, command, left_sample, right_sample, tap_index, tap_weight,
    output ready
  );
endinterface

/* hdl/sfir_out_if.sv */
// sfir_out_if: result channel of the stereo fir filter, valid/ready with result payload
// depends on sfir_pkg
interface sfir_out_if import sfir_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_result;
  logic signed [SAMPLE_BITS-1:0] right_result;
  logic                          clipped;

  modport source (
    output valid, left_result, right_result, clipped,
    input  ready
  );
  modport sink (
    input  valid, left_result, right_result, clipped,
    output ready
  );
endinterface

/* hdl/sfir_ram.sv */
// sfir_ram: generic single-write, single-read memory with registered read data
// depends on nothing
module sfir_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/sfir_seq.sv */
// sfir_seq: sequencer of the stereo fir filter; head pointer, fill count, weight
// valid bits, tap address generation and read pipeline control; depends on sfir_pkg
module sfir_seq import sfir_pkg::*; #(
  parameter int  TAPS = TAPS_DEF,
  localparam int AW   = $clog2(TAPS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  command,
  input  logic [INDEX_BITS-1:0] tap_index,
  input  logic                  out_free,
  output logic                  in_ready,
  output logic                  hist_we,
  output logic [AW-1:0]         hist_wa,
  output logic [AW-1:0]         hist_ra,
  output logic                  wt_we,
  output logic [AW-1:0]         wt_wa,
  output logic [AW-1:0]         wt_ra,
  output logic                  fin_load,
  output mac_ctrl_t             ctrl
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } seq_state_t;

  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  seq_state_t      state;
  seq_state_t      state_next;
  logic [AW-1:0]   ptr;       // history slot of the next sample
  logic [AW-1:0]   fill;      // samples seen so far, held at TAPS-1
  logic [TAPS-1:0] wvalid;    // coefficient written since reset
  logic [AW-1:0]   k;         // tap under read
  logic [AW-1:0]   rd_hist;   // history slot of tap k
  logic            rd_v;
  logic            rd_ok;
  logic            prod_v;
  logic            accept;
  logic            sample_go;
  logic            load_go;
  logic            tap_ok;

  // input transfer decode
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign sample_go = accept && (command == CMD_SAMPLE);
  assign load_go   = accept && (command == CMD_LOAD);

  // memory ports
  assign wt_we   = load_go && (int'(tap_index) < TAPS);
  assign wt_wa   = AW'(tap_index);
  assign wt_ra   = k;
  assign hist_we = sample_go;
  assign hist_wa = ptr;
  assign hist_ra = rd_hist;

  // a tap contributes only if its weight was written and its sample exists
  assign tap_ok = wvalid[k] && (k <= fill);

  // lane control
  assign fin_load      = (state == ST_FINISH) && out_free;
  assign ctrl.clear    = sample_go;
  assign ctrl.mul_en   = rd_v;
  assign ctrl.mul_zero = !rd_ok;
  assign ctrl.acc_en   = prod_v;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_go) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (k == LAST) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_v && !prod_v) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state, pointers and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ptr     <= '0;
      fill    <= '0;
      wvalid  <= '0;
      k       <= '0;
      rd_hist <= '0;
      rd_v    <= 1'b0;
      rd_ok   <= 1'b0;
      prod_v  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_v   <= (state == ST_RUN);
      rd_ok  <= tap_ok;
      prod_v <= rd_v;
      if (wt_we) begin
        wvalid[wt_wa] <= 1'b1;
      end
      if (sample_go) begin
        k       <= '0;
        rd_hist <= ptr;
        ptr     <= (ptr == LAST) ? '0 : ptr + 1'b1;
      end else if (state == ST_RUN) begin
        k       <= k + 1'b1;
        rd_hist <= (rd_hist == '0) ? LAST : rd_hist - 1'b1;
      end
      if (fin_load && (fill != LAST)) begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule

/* hdl/sfir_mac.sv */
// sfir_mac: one channel lane; registered product, wide accumulator, round half up
// and saturation to the sample range; depends on sfir_pkg
module sfir_mac import sfir_pkg::*; #(
  parameter int  TAPS        = TAPS_DEF,
  parameter int  SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int  WEIGHT_BITS = WEIGHT_BITS_DEF,
  localparam int PROD_BITS   = SAMPLE_BITS + WEIGHT_BITS,
  localparam int ACC_RAW     = PROD_BITS + $clog2(TAPS) + 1,
  localparam int ACC_BITS    = (ACC_RAW > ACC_LIMIT) ? ACC_LIMIT : ACC_RAW,
  localparam int SH_BITS     = ACC_BITS - WEIGHT_BITS + 1
) (
  input  logic                          clk,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [WEIGHT_BITS-1:0] weight,
  output logic signed [SAMPLE_BITS-1:0] result,
  output logic                          sat
);

  localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (WEIGHT_BITS - 2);

  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  rnd;
  logic signed [ACC_BITS-1:0]  shifted;
  logic        [SH_BITS-1:0]   sv;
  logic [SH_BITS-SAMPLE_BITS:0] top;

  // product stage and accumulator
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      // keep the multiply in a signed context of its own
      if (ctrl.mul_zero) begin
        prod <= '0;
      end else begin
        prod <= sample * weight;
      end
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_BITS'(prod);
    end
  end

  // round half up, drop the fraction bits, saturate
  assign rnd     = acc + HALF;
  assign shifted = rnd >>> (WEIGHT_BITS - 1);
  assign sv      = shifted[SH_BITS-1:0];
  assign top     = sv[SH_BITS-1:SAMPLE_BITS-1];
  assign sat     = !((&top) || !(|top));

  always_comb begin
    if (!sat) begin
      result = sv[SAMPLE_BITS-1:0];
    end else if (sv[SH_BITS-1]) begin
      result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

/* hdl/stereo_fir_filter.sv */
// stereo_fir_filter: 40-tap direct-form fir on a stereo stream, one shared weight set
// latency: tap reads, read data and product registers, then the finish state loads the result once the output is free
// throughput: one tap read per cycle from the history memory; no new sample is taken until
// the result is loaded; a coefficient load gives no result
// reset: synchronous, clears history fill count and weight valid bits, no clearing pass
// depends on sfir_pkg, sfir_in_if, sfir_out_if, sfir_ram, sfir_seq, sfir_mac
module stereo_fir_filter import sfir_pkg::*; #(
  parameter int  TAPS        = TAPS_DEF,
  parameter int  SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int  WEIGHT_BITS = WEIGHT_BITS_DEF,
  localparam int AW          = $clog2(TAPS)
) (
  input  logic       clk,
  input  logic       rst,
  sfir_in_if.sink    audio,
  sfir_out_if.source filtered
);

  logic                          hist_we;
  logic [AW-1:0]                 hist_wa;
  logic [AW-1:0]                 hist_ra;
  logic [2*SAMPLE_BITS-1:0]      hist_rd;
  logic                          wt_we;
  logic [AW-1:0]                 wt_wa;
  logic [AW-1:0]                 wt_ra;
  logic [WEIGHT_BITS-1:0]        wt_rd;
  logic                          fin_load;
  mac_ctrl_t                     ctrl;
  logic signed [SAMPLE_BITS-1:0] left_sum;
  logic signed [SAMPLE_BITS-1:0] right_sum;
  logic                          left_sat;
  logic                          right_sat;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [SAMPLE_BITS-1:0] right_q;
  logic                          clipped_q;

  // sequencer
  sfir_seq #(.TAPS(TAPS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (audio.valid),
    .command   (audio.command),
    .tap_index (audio.tap_index),
    .out_free  (!out_valid || filtered.ready),
    .in_ready  (audio.ready),
    .hist_we   (hist_we),
    .hist_wa   (hist_wa),
    .hist_ra   (hist_ra),
    .wt_we     (wt_we),
    .wt_wa     (wt_wa),
    .wt_ra     (wt_ra),
    .fin_load  (fin_load),
    .ctrl      (ctrl)
  );

  // history ring, left and right side by side
  sfir_ram #(.WIDTH(2*SAMPLE_BITS), .DEPTH(TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_wa),
    .wdata ({audio.left_sample, audio.right_sample}),
    .raddr (hist_ra),
    .rdata (hist_rd)
  );

  // coefficient store
  sfir_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(TAPS)) u_wt_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_wa),
    .wdata (audio.tap_weight),
    .raddr (wt_ra),
    .rdata (wt_rd)
  );

  // channel lanes
  sfir_mac #(.TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_mac_left (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample ($signed(hist_rd[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .weight ($signed(wt_rd)),
    .result (left_sum),
    .sat    (left_sat)
  );

  sfir_mac #(.TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_mac_right (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample ($signed(hist_rd[SAMPLE_BITS-1:0])),
    .weight ($signed(wt_rd)),
    .result (right_sum),
    .sat    (right_sat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (filtered.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      left_q    <= left_sum;
      right_q   <= right_sum;
      clipped_q <= left_sat || right_sat;
    end
  end

  assign filtered.valid        = out_valid;
  assign filtered.left_result  = left_q;
  assign filtered.right_result = right_q;
  assign filtered.clipped      = clipped_q;

  // results leave only once the tap pipeline has drained
  a_drained_at_finish: assert property (@(posedge clk) disable iff (rst)
    fin_load |-> (!ctrl.mul_en && !ctrl.acc_en))
    else $error("result taken while taps still in flight");

  // coefficients never change under a running sum
  a_no_load_in_run: assert property (@(posedge clk) disable iff (rst)
    wt_we |-> (!ctrl.mul_en && !ctrl.acc_en && !fin_load))
    else $error("coefficient write during a filter pass");

  // a new result appears only from a finish load
  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(filtered.valid) |-> $past(fin_load))
    else $error("result valid without a finish load");

endmodule
